@@ rtl/pba_pkg.sv @@
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants for the bitmap page allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

    // field widths
    localparam int IDX_W      = 14;      // page number
    localparam int LIM_W      = 15;      // page limit and free count
    localparam int INDEX_SPAN = 16384;   // pages a 14-bit index can name

    // bitmap word organisation
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;           // log2(WORD_W)

    localparam int NUM_PAGES_DEF = 16384;

    // opcodes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RESERVE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOM   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [IDX_W-1:0] page_index;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] result_page;
        logic [LIM_W-1:0] free_pages;
    } t_out_word;

    // result of a first-free search over one bitmap word
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_idx;
    } t_find;

endpackage

@@ rtl/pba_first_zero.sv @@
// ----------------------------------------------------------------------------
// pba_first_zero
// Finds the lowest clear bit of a bitmap word among the bits enabled by mask.
// ----------------------------------------------------------------------------
module pba_first_zero (
    input  logic [pba_pkg::WORD_W-1:0] i_word,
    input  logic [pba_pkg::WORD_W-1:0] i_mask,
    output pba_pkg::t_find             o_find
);

    logic [pba_pkg::WORD_W-1:0] free_bits;
    logic [pba_pkg::WORD_W-1:0] lowest;
    logic [pba_pkg::BIT_W-1:0]  enc;

    // isolate the lowest free bit: x & -x
    assign free_bits = ~i_word & i_mask;
    assign lowest    = free_bits & (~free_bits + pba_pkg::WORD_W'(1));

    // one-hot to binary, each output bit an independent OR
    always_comb begin
        enc = '0;
        for (int b = 0; b < pba_pkg::WORD_W; b++) begin
            enc = enc | (lowest[b] ? pba_pkg::BIT_W'(b) : '0);
        end
    end

    assign o_find.found   = |free_bits;
    assign o_find.bit_idx = enc;

endmodule

@@ rtl/page_bitmap_allocator_top.sv @@
// ----------------------------------------------------------------------------
// page_bitmap_allocator_top
// First-fit page allocator over a used-page bitmap held in a word-wide RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                    | word
//  --------+-----------+------------------------------+-------------------------
//  in      | input     | i_in_valid  / o_in_ready     | t_in_word  (op, index)
//  out     | output    | o_out_valid / i_out_ready    | t_out_word (status, page,
//          |           |                              |             free count)
//  cfg     | input     | i_cfg_valid / o_cfg_ready    | page_limit, 15 bits
//
//  Free and reserve read the RAM word, then write it back. Allocate reads the
//  bitmap words one per cycle from the lowest word that may hold a free page
//  up to the limit (at most NUM_WORDS, 512). Out-of-range and no-op words, and
//  an allocate with no word left to scan, answer without a RAM access.
//  After reset a clearing pass writes the bitmap to all-used, one word a cycle,
//  over ceil(min(NUM_PAGES,16384)/32) words (512 by default); no input is taken
//  meanwhile, configuration writes are. One word in flight; a waiting result
//  does not block the next accept when it is taken in the same cycle.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_top #(
    parameter int NUM_PAGES = pba_pkg::NUM_PAGES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  pba_pkg::t_in_word         i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output pba_pkg::t_out_word        o_out,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [pba_pkg::LIM_W-1:0] i_cfg_data
);

    localparam int SPAN      = (NUM_PAGES < pba_pkg::INDEX_SPAN) ? NUM_PAGES
                                                                 : pba_pkg::INDEX_SPAN;
    localparam int NUM_WORDS = (SPAN + pba_pkg::WORD_W - 1) / pba_pkg::WORD_W;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int HINT_W    = $clog2(NUM_WORDS + 1);

    localparam int IDX_W = pba_pkg::IDX_W;
    localparam int LIM_W = pba_pkg::LIM_W;
    localparam int WORD_W = pba_pkg::WORD_W;
    localparam int BIT_W = pba_pkg::BIT_W;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_RMW   = 4'b0100,
        S_SCAN  = 4'b1000
    } t_state;

    // control registers
    t_state             r_state, n_state;
    logic [WADDR_W-1:0] r_clr, n_clr;
    logic [HINT_W-1:0]  r_hint, n_hint;     // lowest word that may hold a free page
    logic [LIM_W-1:0]   r_free, n_free;
    logic [LIM_W-1:0]   r_limit;
    logic               r_out_valid, n_out_valid;

    // payload registers
    logic [1:0]         r_op, n_op;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [WADDR_W-1:0] r_scan, n_scan;
    pba_pkg::t_out_word r_out, n_out;

    // bitmap RAM
    logic [WORD_W-1:0]  r_mem [NUM_WORDS];
    logic [WORD_W-1:0]  r_rdata;
    logic               mem_we, mem_re;
    logic [WADDR_W-1:0] mem_waddr, mem_raddr;
    logic [WORD_W-1:0]  mem_wdata;

    logic               in_acc, out_take;
    logic [LIM_W-1:0]   lim_eff, lim_m1;
    logic               lim_zero;
    logic [WADDR_W-1:0] last_word;
    logic [BIT_W-1:0]   tail;
    logic [WORD_W-1:0]  scan_mask;
    logic [WADDR_W-1:0] idx_word, ridx_word;
    logic [BIT_W-1:0]   ridx_bit;
    logic               cur_bit;
    pba_pkg::t_find     find;

    logic               fin;
    logic [1:0]         fin_status;
    logic [IDX_W-1:0]   fin_page;

    // handshakes
    assign o_cfg_ready = i_rst_n;
    assign out_take    = r_out_valid & i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) & (~r_out_valid | i_out_ready);
    assign in_acc      = i_in_valid & o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // limit in force and the last bitmap word it reaches
    assign lim_eff   = (r_limit > LIM_W'(SPAN)) ? LIM_W'(SPAN) : r_limit;
    assign lim_zero  = (lim_eff == '0);
    assign lim_m1    = lim_eff - LIM_W'(1);
    assign last_word = WADDR_W'(lim_m1[IDX_W-1:BIT_W]);
    assign tail      = lim_eff[BIT_W-1:0];

    // only the last word can be partly beyond the limit
    assign scan_mask = ((r_scan == last_word) && (tail != '0))
                     ? ~({WORD_W{1'b1}} << tail) : {WORD_W{1'b1}};

    assign idx_word  = WADDR_W'(i_in.page_index[IDX_W-1:BIT_W]);
    assign ridx_word = WADDR_W'(r_idx[IDX_W-1:BIT_W]);
    assign ridx_bit  = r_idx[BIT_W-1:0];
    assign cur_bit   = r_rdata[ridx_bit];

    pba_first_zero u_first_zero (
        .i_word (r_rdata),
        .i_mask (scan_mask),
        .o_find (find)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_hint      = r_hint;
        n_free      = r_free;
        n_op        = r_op;
        n_idx       = r_idx;
        n_scan      = r_scan;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~out_take;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_scan;
        mem_raddr   = r_scan;
        mem_wdata   = r_rdata;
        fin         = 1'b0;
        fin_status  = pba_pkg::ST_OK;
        fin_page    = r_idx;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = {WORD_W{1'b1}};
                if (r_clr == WADDR_W'(NUM_WORDS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + WADDR_W'(1);
                end
            end

            S_IDLE: begin
                if (in_acc) begin
                    n_op  = i_in.opcode;
                    n_idx = i_in.page_index;
                    fin_page = i_in.page_index;
                    case (i_in.opcode)
                        pba_pkg::OP_ALLOC: begin
                            if (lim_zero || (r_hint > HINT_W'(last_word))) begin
                                fin        = 1'b1;
                                fin_status = pba_pkg::ST_OOM;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = WADDR_W'(r_hint);
                                n_scan    = WADDR_W'(r_hint);
                                n_state   = S_SCAN;
                            end
                        end
                        pba_pkg::OP_FREE, pba_pkg::OP_RESERVE: begin
                            if ({1'b0, i_in.page_index} >= lim_eff) begin
                                fin        = 1'b1;
                                fin_status = pba_pkg::ST_RANGE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = idx_word;
                                n_state   = S_RMW;
                            end
                        end
                        default: begin
                            fin = 1'b1;     // no operation
                        end
                    endcase
                end
            end

            // read word is in r_rdata: flip the bit if it changes
            S_RMW: begin
                mem_waddr = ridx_word;
                fin       = 1'b1;
                n_state   = S_IDLE;
                if (r_op == pba_pkg::OP_FREE) begin
                    if (cur_bit) begin
                        mem_we    = 1'b1;
                        mem_wdata = r_rdata & ~(WORD_W'(1) << ridx_bit);
                        if (r_free < LIM_W'(pba_pkg::INDEX_SPAN)) begin
                            n_free = r_free + LIM_W'(1);
                        end
                        if (HINT_W'(ridx_word) < r_hint) begin
                            n_hint = HINT_W'(ridx_word);
                        end
                    end
                end else begin
                    if (!cur_bit) begin
                        mem_we    = 1'b1;
                        mem_wdata = r_rdata | (WORD_W'(1) << ridx_bit);
                        if (r_free != '0) begin
                            n_free = r_free - LIM_W'(1);
                        end
                    end
                end
            end

            // one word a cycle; the next read is issued while testing this one
            S_SCAN: begin
                if (find.found) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_scan;
                    mem_wdata = r_rdata | (WORD_W'(1) << find.bit_idx);
                    if (r_free != '0) begin
                        n_free = r_free - LIM_W'(1);
                    end
                    n_hint   = HINT_W'(r_scan);
                    fin      = 1'b1;
                    fin_page = IDX_W'({r_scan, find.bit_idx});
                    n_state  = S_IDLE;
                end else if (r_scan == last_word) begin
                    // words below the last one are full
                    n_hint     = HINT_W'(last_word);
                    fin        = 1'b1;
                    fin_status = pba_pkg::ST_OOM;
                    n_state    = S_IDLE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_scan + WADDR_W'(1);
                    n_scan    = r_scan + WADDR_W'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // load the result register
        if (fin) begin
            n_out_valid       = 1'b1;
            n_out.status      = fin_status;
            n_out.result_page = fin_page;
            n_out.free_pages  = n_free;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_hint      <= HINT_W'(NUM_WORDS);
            r_free      <= '0;
            r_limit     <= LIM_W'(pba_pkg::INDEX_SPAN);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_hint      <= n_hint;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_idx  <= n_idx;
        r_scan <= n_scan;
        r_out  <= n_out;
    end

    // bitmap RAM, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

endmodule

@@ rtl/pba_checker.sv @@
// ----------------------------------------------------------------------------
// pba_checker
// Port-level checks on the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pba_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input pba_pkg::t_out_word o_out
);

    // a result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result word dropped or changed while stalled");

    // an accepted word either answers at once or keeps the input busy
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (o_out_valid || !o_in_ready))
        else $error("second word taken while the first is in progress");

    // no accept while a result waits and is not being taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted over a stalled result");

    // the free count never exceeds the page span
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.free_pages <= 15'd16384))
        else $error("free page count out of range");

endmodule

bind page_bitmap_allocator_top pba_checker u_pba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

@@ sim/tb_page_bitmap_allocator_top.sv @@
// ----------------------------------------------------------------------------
// tb_page_bitmap_allocator_top
// Self-checking bench for the first-fit bitmap page allocator. A short table
// of directed words (reset state, index extremes, every opcode, range and
// out-of-memory cases, limit extremes) is followed by random phases, each at
// its own page limit. Every accepted word goes through a shadow allocator in
// the bench. Its answer, or a row's typed one, is queued and compared field
// by field with the block's answers. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_page_bitmap_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IDX_W      = pba_pkg::IDX_W;
    localparam int          LIM_W      = pba_pkg::LIM_W;
    localparam logic [1:0]  OP_ALLOC   = pba_pkg::OP_ALLOC;
    localparam logic [1:0]  OP_FREE    = pba_pkg::OP_FREE;
    localparam logic [1:0]  OP_RESERVE = pba_pkg::OP_RESERVE;
    localparam logic [1:0]  ST_OK      = pba_pkg::ST_OK;
    localparam logic [1:0]  ST_OOM     = pba_pkg::ST_OOM;
    localparam logic [1:0]  ST_RANGE   = pba_pkg::ST_RANGE;

    localparam int          TB_SPAN   = pba_pkg::INDEX_SPAN;
    localparam int          TB_PAGES  = pba_pkg::NUM_PAGES_DEF;
    localparam logic [1:0]  OP_UNUSED = 2'd3;      // no operation
    localparam int          LONG_HOLD = 200;       // receiver hold-off, cycles
    localparam int          TAIL_WAIT = 32;

    typedef struct {
        bit                  known;       // expectation typed into the table
        pba_pkg::t_out_word  want;
    } t_launch_tag;

    typedef struct {
        bit                  is_cfg;
        logic [LIM_W-1:0]    limit;
        pba_pkg::t_in_word   w;
        bit                  known;
        pba_pkg::t_out_word  want;
    } t_dir_row;

    // DUT ports
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    pba_pkg::t_in_word  i_in        = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    pba_pkg::t_out_word o_out;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [LIM_W-1:0]   i_cfg_data  = '0;

    // shadow allocator state
    bit                shadow_used [TB_PAGES];
    int unsigned       shadow_free;
    logic [LIM_W-1:0]  shadow_limit;

    t_launch_tag        launch_tags[$];
    pba_pkg::t_out_word pending_outcomes[$];

    int unsigned       words_offered  = 0;
    int unsigned       results_seen   = 0;
    int unsigned       mismatches     = 0;
    int unsigned       limit_writes   = 0;
    int unsigned       status_seen [4];
    bit                long_hold_req  = 1'b0;
    bit                tail_calm      = 1'b0;

    page_bitmap_allocator_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // one line per mismatch
    task automatic flag_mismatch(string what, int got, int want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
                 $time, what, got, want, results_seen);
    endtask

    // apply one word to the shadow allocator, return the answer it must give
    function automatic pba_pkg::t_out_word apply_page_op(pba_pkg::t_in_word w);
        int unsigned        lim;
        int unsigned        p;
        pba_pkg::t_out_word r;
        lim = (int'(shadow_limit) > TB_SPAN) ? TB_SPAN : int'(shadow_limit);
        if (lim > TB_PAGES) lim = TB_PAGES;
        r.status      = ST_OK;
        r.result_page = w.page_index;
        case (w.opcode)
            OP_ALLOC: begin
                p = 0;
                while (p < lim && shadow_used[p]) p++;
                if (p < lim) begin
                    shadow_used[p] = 1'b1;
                    if (shadow_free > 0) shadow_free--;
                    r.result_page = IDX_W'(p);
                end else begin
                    r.status = ST_OOM;
                end
            end
            OP_FREE: begin
                if (w.page_index >= lim) begin
                    r.status = ST_RANGE;
                end else if (shadow_used[w.page_index]) begin
                    shadow_used[w.page_index] = 1'b0;
                    if (shadow_free < TB_SPAN) shadow_free++;
                end
            end
            OP_RESERVE: begin
                if (w.page_index >= lim) begin
                    r.status = ST_RANGE;
                end else if (!shadow_used[w.page_index]) begin
                    shadow_used[w.page_index] = 1'b1;
                    if (shadow_free > 0) shadow_free--;
                end
            end
            default: ;
        endcase
        r.free_pages = LIM_W'(shadow_free);
        return r;
    endfunction

    // random word, mostly well formed for the limit in force
    function automatic pba_pkg::t_in_word random_page_op(int unsigned lim);
        pba_pkg::t_in_word w;
        int unsigned       pick;
        pick = $urandom_range(99, 0);
        if (pick < 45)      w.opcode = OP_ALLOC;
        else if (pick < 80) w.opcode = OP_FREE;
        else if (pick < 94) w.opcode = OP_RESERVE;
        else                w.opcode = OP_UNUSED;
        pick = $urandom_range(9, 0);
        if (w.opcode == OP_ALLOC || pick == 0 || lim == 0)
            w.page_index = IDX_W'($urandom);
        else if (pick == 1 && lim < TB_SPAN)
            w.page_index = IDX_W'($urandom_range(TB_SPAN - 1, lim));
        else
            w.page_index = IDX_W'($urandom_range(lim - 1, 0));
        return w;
    endfunction

    function automatic t_dir_row op_row(logic [1:0] op, int idx);
        t_dir_row r;
        r = '{is_cfg: 1'b0, limit: '0, w: '0, known: 1'b0, want: '0};
        r.w.opcode     = op;
        r.w.page_index = IDX_W'(idx);
        return r;
    endfunction

    function automatic t_dir_row chk_row(logic [1:0] op, int idx, logic [1:0] st,
                                         int pg, int fp);
        t_dir_row r;
        r = op_row(op, idx);
        r.known            = 1'b1;
        r.want.status      = st;
        r.want.result_page = IDX_W'(pg);
        r.want.free_pages  = LIM_W'(fp);
        return r;
    endfunction

    function automatic t_dir_row cfg_row(int v);
        t_dir_row r;
        r = op_row(OP_UNUSED, 0);
        r.is_cfg = 1'b1;
        r.limit  = LIM_W'(v);
        return r;
    endfunction

    // offer one word, with an occasional idle burst in front of it
    task automatic offer_word(pba_pkg::t_in_word w, bit known, pba_pkg::t_out_word want);
        t_launch_tag t;
        t.known = known;
        t.want  = want;
        if (!tail_calm && $urandom_range(3, 0) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge i_clk);
        end
        launch_tags.push_back(t);
        words_offered++;
        i_in_valid <= 1'b1;
        i_in       <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (results_seen < words_offered) @(posedge i_clk);
    endtask

    // limit changes only with the block idle
    task automatic write_page_limit(logic [LIM_W-1:0] v);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_writes++;
    endtask

    // shadow state after reset
    initial begin
        foreach (shadow_used[p]) shadow_used[p] = 1'b1;
        shadow_free  = 0;
        shadow_limit = LIM_W'(TB_SPAN);
        foreach (status_seen[s]) status_seen[s] = 0;
    end

    // watch all three channels at each edge; input side first
    always @(posedge i_clk) begin : scoreboard
        t_launch_tag        tag;
        pba_pkg::t_out_word pred;
        pba_pkg::t_out_word want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) shadow_limit = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                tag  = launch_tags.pop_front();
                pred = apply_page_op(i_in);
                pending_outcomes.push_back(tag.known ? tag.want : pred);
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_outcomes.size() == 0) begin
                    flag_mismatch("unexpected result page", o_out.result_page, -1);
                end else begin
                    want = pending_outcomes.pop_front();
                    status_seen[want.status]++;
                    if (o_out.status != want.status)
                        flag_mismatch("status", o_out.status, want.status);
                    if (o_out.result_page != want.result_page)
                        flag_mismatch("result_page", o_out.result_page, want.result_page);
                    if (o_out.free_pages != want.free_pages)
                        flag_mismatch("free_pages", o_out.free_pages, want.free_pages);
                end
                results_seen++;
            end
        end
    end

    // receiver: ready bursts, stall bursts, one long hold-off on request
    initial begin : out_ready_gen
        forever begin
            if (long_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (!tail_calm && $urandom_range(3, 0) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(15, 1)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(20, 1)) @(posedge i_clk);
            end
        end
    end

    // main sequence
    initial begin : stimulus
        t_dir_row    rows[$];
        int          phase_limit[];
        int          phase_words[];
        int unsigned lim;
        int          v;

        phase_limit = '{64, 1, 200, 16384, 32, 32767, 0, 128, 9, -1, 48};
        phase_words = '{80, 20, 90, 40, 80, 30, 10, 80, 60, 80, 80};

        // after reset: all pages used, count zero, limit 16384
        rows.push_back(chk_row(OP_ALLOC,   16383, ST_OOM,   16383, 0));
        rows.push_back(chk_row(OP_FREE,    0,     ST_OK,    0,     1));
        rows.push_back(chk_row(OP_FREE,    16383, ST_OK,    16383, 2));
        rows.push_back(chk_row(OP_FREE,    16383, ST_OK,    16383, 2));  // already free
        rows.push_back(chk_row(OP_RESERVE, 5,     ST_OK,    5,     2));  // already used
        rows.push_back(chk_row(OP_ALLOC,   0,     ST_OK,    0,     1));
        rows.push_back(chk_row(OP_ALLOC,   0,     ST_OK,    16383, 0));  // top page
        rows.push_back(chk_row(OP_ALLOC,   1234,  ST_OOM,   1234,  0));
        rows.push_back(chk_row(OP_FREE,    5,     ST_OK,    5,     1));
        rows.push_back(chk_row(OP_RESERVE, 5,     ST_OK,    5,     0));
        rows.push_back(chk_row(OP_UNUSED,  10922, ST_OK,    10922, 0));
        rows.push_back(chk_row(OP_UNUSED,  5461,  ST_OK,    5461,  0));
        rows.push_back(op_row(OP_FREE,  100));
        rows.push_back(op_row(OP_FREE,  37));
        rows.push_back(op_row(OP_ALLOC, 0));
        // smallest limit; page 100 stays counted but out of reach
        rows.push_back(cfg_row(1));
        rows.push_back(chk_row(OP_FREE,    1,     ST_RANGE, 1,     1));
        rows.push_back(chk_row(OP_RESERVE, 16383, ST_RANGE, 16383, 1));
        rows.push_back(chk_row(OP_FREE,    0,     ST_OK,    0,     2));
        rows.push_back(chk_row(OP_ALLOC,   77,    ST_OK,    0,     1));
        rows.push_back(chk_row(OP_ALLOC,   3,     ST_OOM,   3,     1));
        // zero limit: nothing searchable or changeable
        rows.push_back(cfg_row(0));
        rows.push_back(chk_row(OP_ALLOC,   9,     ST_OOM,   9,     1));
        rows.push_back(chk_row(OP_FREE,    0,     ST_RANGE, 0,     1));
        // limit above the index span is capped
        rows.push_back(cfg_row(32767));
        rows.push_back(op_row(OP_ALLOC, 0));
        rows.push_back(op_row(OP_FREE,  16383));
        rows.push_back(cfg_row(8));
        rows.push_back(chk_row(OP_RESERVE, 16383, ST_RANGE, 16383, 1));
        rows.push_back(op_row(OP_ALLOC, 4660));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            if (rows[r].is_cfg) write_page_limit(rows[r].limit);
            else offer_word(rows[r].w, rows[r].known, rows[r].want);
        end

        // random phases, one page limit each
        foreach (phase_limit[ph]) begin
            v = (phase_limit[ph] < 0) ? int'($urandom_range(600, 2)) : phase_limit[ph];
            write_page_limit(LIM_W'(v));
            lim = (v > TB_SPAN) ? TB_SPAN : v;
            if (ph == 2) long_hold_req = 1'b1;          // let the block back up
            if (ph == phase_limit.size() - 1) tail_calm = 1'b1;
            for (int k = 0; k < phase_words[ph]; k++) begin
                if (ph == 4 && k == phase_words[ph] / 2) drain_results();
                offer_word(random_page_op(lim), 1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (pending_outcomes.size() != 0)
            flag_mismatch("results never delivered", pending_outcomes.size(), 0);

        $display("Run covered %0d words over %0d page-limit settings, %0d results checked.",
                 words_offered, limit_writes, results_seen);
        $display("Answers: %0d ok, %0d out of memory, %0d index out of range.",
                 status_seen[ST_OK], status_seen[ST_OOM], status_seen[ST_RANGE]);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #80_000_000;
        $display("[%0t] timeout: %0d words offered, %0d results seen",
                 $time, words_offered, results_seen);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pba_pkg.sv
rtl/pba_first_zero.sv
rtl/page_bitmap_allocator_top.sv
rtl/pba_checker.sv
sim/tb_page_bitmap_allocator_top.sv
